// ===== rtl/lpmrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmrt_pkg - shared types and constants for the LPM route table
// Table size, request record handed cell to cell, write-back record, codes.
// ----------------------------------------------------------------------------
package lpmrt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 6;
	localparam logic [LEN_W-1:0] FULL_LENGTH = LEN_W'(32);

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_LOOKUP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_UPDATED   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// request as it walks the chain, with what the cells so far have found
	typedef struct packed {
		logic              vld;
		kind_t             kind;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] net;
		logic [ADDR_W-1:0] hop;
		logic              hit;      // exact network/length match seen
		logic              free_ok;  // a free slot seen
		logic [IDX_W-1:0]  free_idx; // lowest free slot
		logic              best_ok;  // lookup: some route covers addr
		logic [LEN_W-1:0]  best_len;
		logic [ADDR_W-1:0] best_hop;
	} req_t;

	// new-route write, broadcast to every cell from the chain tail
	typedef struct packed {
		logic              wr;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] net;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] hop;
	} commit_t;

	// network mask for a prefix length of 0..32
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		prefix_mask = ~({ADDR_W{1'b1}} >> len);
	endfunction

endpackage

// ===== rtl/longest_prefix_match_route_table.sv =====
// ----------------------------------------------------------------------------
// longest_prefix_match_route_table - IPv4 LPM route table, chain of slot cells
// Add / remove / clear / lookup requests walk a row of route cells.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  request   | start, busy            | kind, address, pfx_len, hop_address
//  result    | done (1-cycle strobe)  | status, found, result_hop
//
// A request passes one register ahead of the chain, one register per route cell
//   and one result register between accept and the done strobe.
//   Only one request is in flight at a time.
// busy is high from the accept edge until the edge that loads the result, so
//   the next request may be accepted in the very cycle done is shown.
// Reset empties the table at once (valid bits only); no clearing pass.
// The receiver cannot stall: done is shown for exactly one cycle.
//
module longest_prefix_match_route_table
	import lpmrt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        kind,
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0]  pfx_len,
	input  logic [ADDR_W-1:0] hop_address,
	output logic              done,
	output logic [1:0]        status,
	output logic              found,
	output logic [ADDR_W-1:0] result_hop
);

	// chain[k] feeds cell k; chain[CAPACITY] is the tail register
	req_t              chain [CAPACITY+1];
	req_t              head_q;
	req_t              head_d;
	commit_t           commit;
	req_t              tail;

	logic              busy_q;
	logic              done_q;
	status_t           status_q;
	logic              found_q;
	logic [ADDR_W-1:0] hop_q;

	logic              accept;
	logic [LEN_W-1:0]  len_clamped;

	status_t           res_status;
	logic              res_found;
	logic [ADDR_W-1:0] res_hop;

	assign accept = start && !busy_q;

	// saturate anything above /32, mask the destination to its network
	assign len_clamped = (pfx_len > FULL_LENGTH) ? FULL_LENGTH : pfx_len;

	always_comb begin
		head_d          = '0;
		head_d.vld      = 1'b1;
		head_d.kind     = kind_t'(kind);
		head_d.addr     = address;
		head_d.len      = len_clamped;
		head_d.net      = address & prefix_mask(len_clamped);
		head_d.hop      = hop_address;
	end

	// head register: only the valid flag travels without a load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (accept) begin
			head_q <= head_d;
		end else begin
			head_q.vld <= 1'b0;
		end
	end

	assign chain[0] = head_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lpmrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(i)),
			.req_i    (chain[i]),
			.commit_i (commit),
			.req_o    (chain[i+1])
		);
	end

	assign tail = chain[CAPACITY];

	// a new route is written only once the whole table has been seen to hold
	// no exact match; the lowest free slot found on the way takes it
	always_comb begin
		commit     = '0;
		commit.wr  = tail.vld && (tail.kind == KIND_ADD) && !tail.hit && tail.free_ok;
		commit.idx = tail.free_idx;
		commit.net = tail.net;
		commit.len = tail.len;
		commit.hop = tail.hop;
	end

	// result from the tail record
	always_comb begin
		res_status = ST_DONE;
		res_found  = 1'b0;
		res_hop    = '0;
		case (tail.kind)
			KIND_ADD: begin
				if (tail.hit) begin
					res_status = ST_UPDATED;
				end else if (!tail.free_ok) begin
					res_status = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				if (!tail.hit) begin
					res_status = ST_NOT_FOUND;
				end
			end
			KIND_CLEAR: begin
				res_status = ST_DONE;
			end
			KIND_LOOKUP: begin
				if (tail.best_ok) begin
					res_found = 1'b1;
					// zero hop: directly attached, forward to the address itself
					res_hop   = (tail.best_hop == '0) ? tail.addr : tail.best_hop;
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= tail.vld;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.vld) begin
			status_q <= res_status;
			found_q  <= res_found;
			hop_q    <= res_hop;
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign status     = status_q;
	assign found      = found_q;
	assign result_hop = hop_q;

endmodule

// ===== rtl/lpmrt_cell.sv =====
// ----------------------------------------------------------------------------
// lpmrt_cell - one route slot of the chain
// Holds one entry, inspects the passing request, hands it on registered.
// ----------------------------------------------------------------------------
module lpmrt_cell
	import lpmrt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  req_t             req_i,
	input  commit_t          commit_i,
	output req_t             req_o
);

	logic              valid_q;
	logic [ADDR_W-1:0] net_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] hop_q;
	req_t              out_q;
	req_t              nxt;

	logic exact;
	logic covers;
	logic do_hop;
	logic do_inval;
	logic do_fill;

	assign exact  = valid_q && (len_q == req_i.len) && (net_q == req_i.net);
	assign covers = valid_q && ((req_i.addr & prefix_mask(len_q)) == net_q);
	assign do_fill = commit_i.wr && (commit_i.idx == idx);

	always_comb begin
		nxt      = req_i;
		do_hop   = 1'b0;
		do_inval = 1'b0;
		if (req_i.vld) begin
			case (req_i.kind)
				KIND_ADD: begin
					if (exact) begin
						nxt.hit = 1'b1;
						do_hop  = 1'b1;
					end
					if (!valid_q && !req_i.free_ok) begin
						nxt.free_ok  = 1'b1;
						nxt.free_idx = idx;
					end
				end
				KIND_REMOVE: begin
					if (exact) begin
						nxt.hit  = 1'b1;
						do_inval = 1'b1;
					end
				end
				KIND_CLEAR: begin
					do_inval = 1'b1;
				end
				KIND_LOOKUP: begin
					// strictly longer only: lower slot wins a tie
					if (covers && (!req_i.best_ok || len_q > req_i.best_len)) begin
						nxt.best_ok  = 1'b1;
						nxt.best_len = len_q;
						nxt.best_hop = hop_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (do_fill) begin
			valid_q <= 1'b1;
		end else if (do_inval) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_fill) begin
			net_q <= commit_i.net;
			len_q <= commit_i.len;
			hop_q <= commit_i.hop;
		end else if (do_hop) begin
			hop_q <= req_i.hop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			out_q <= nxt;
		end
	end

	assign req_o = out_q;

endmodule

// ===== rtl/lpmrt_checker.sv =====
// ----------------------------------------------------------------------------
// lpmrt_checker - port-level checks for the LPM route table
// Request/result sequencing and result field consistency.
// ----------------------------------------------------------------------------
module lpmrt_checker
	import lpmrt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [1:0]        status,
	input logic              found,
	input logic [ADDR_W-1:0] result_hop
);

	// an accepted request holds the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request");

	// the result is shown exactly as busy drops
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// no result while a request is still in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	// a hit reports done; a miss or non-lookup carries no hop
	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (status == ST_DONE))
		else $error("found with wrong status");

	a_nohop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (result_hop == '0))
		else $error("hop without a match");

endmodule

bind longest_prefix_match_route_table lpmrt_checker u_lpmrt_checker (.*);
